// ===== hdl/tls_pkg.sv =====
// ----------------------------------------------------------------------------
// tls_pkg
// Types and character codes for the text line splitter.
// ----------------------------------------------------------------------------
package tls_pkg;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;

  // terminator length codes
  localparam logic [1:0] TERM_NONE   = 2'd0;
  localparam logic [1:0] TERM_SINGLE = 2'd1;
  localparam logic [1:0] TERM_PAIR   = 2'd2;

  // scan phase of the line being built
  typedef enum logic [1:0] {
    PH_WS   = 2'd0,
    PH_BODY = 2'd1,
    PH_CR   = 2'd2,
    PH_LF   = 2'd3
  } phase_t;

  // one line record
  typedef struct packed {
    logic [31:0] line_start;
    logic [31:0] line_number;
    logic [31:0] leading_spaces;
    logic [31:0] content_length;
    logic [1:0]  terminator_length;
    logic        final_line;
  } rec_t;

endpackage

// ===== hdl/text_line_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// text_line_splitter_unit
// Splits a byte stream into lines and gives one record per line.
// ----------------------------------------------------------------------------
// Path: a byte is held in the input register until the queue has room; its
// records are then written to the record queue, whose head drives the outputs.
// Throughput: one byte per cycle; a byte may give up to three records, which
// leave through an eight-entry record queue, one record per cycle with out_ready.
// Input stalls only while the queue has fewer than three free entries.
// Reset: rst clears the scan state to offset 0, line 1, and empties the queue.

module text_line_splitter_unit
  import tls_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] line_start,
  output logic [31:0] line_number,
  output logic [31:0] leading_spaces,
  output logic [31:0] content_length,
  output logic [1:0]  terminator_length,
  output logic        final_line
);

  localparam int QDEPTH = 8;
  localparam int PW     = $clog2(QDEPTH);

  // input register
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_last;

  // scan state
  phase_t      phase, phase_next;
  logic [31:0] byte_offset, byte_offset_next;
  logic [31:0] current_start, current_start_next;
  logic [31:0] space_count, space_count_next;
  logic [31:0] body_count, body_count_next;
  logic [31:0] line_counter, line_counter_next;

  // record queue
  rec_t        qmem [QDEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count, count_next;

  rec_t        recs [3];
  logic [1:0]  nrec;
  logic        fire;
  logic        pop;
  logic        pend;
  logic        pair;
  rec_t        head;

  // process the held byte when three queue entries are free
  assign fire     = s_valid && (count <= (PW+1)'(QDEPTH - 3));
  assign in_ready = !s_valid || fire;
  assign out_valid = (count != '0);
  assign pop      = out_valid && out_ready;

  // record generation for one byte
  always_comb begin
    phase_t      ph;
    logic [31:0] st, ln, sp, bd, pos1;
    recs[0] = '0;
    recs[1] = '0;
    recs[2] = '0;
    nrec    = 2'd0;
    ph      = phase;
    st      = current_start;
    ln      = line_counter;
    sp      = space_count;
    bd      = body_count;
    pos1    = byte_offset + 32'd1;
    pend    = (phase == PH_CR) || (phase == PH_LF);
    pair    = ((phase == PH_CR) && (s_byte == CH_LF)) ||
              ((phase == PH_LF) && (s_byte == CH_CR));

    // close a line left open by a lone terminator
    if (pend) begin
      recs[0] = '{line_start: current_start, line_number: line_counter,
                  leading_spaces: space_count, content_length: body_count,
                  terminator_length: pair ? TERM_PAIR : TERM_SINGLE,
                  final_line: 1'b0};
      nrec = 2'd1;
      ln   = line_counter + 32'd1;
      st   = pair ? pos1 : byte_offset;
      sp   = '0;
      bd   = '0;
      ph   = PH_WS;
    end

    // classify the byte
    if (!pair) begin
      if (s_byte == CH_CR) begin
        ph = PH_CR;
      end else if (s_byte == CH_LF) begin
        ph = PH_LF;
      end else if ((ph == PH_WS) && ((s_byte == CH_SPACE) || (s_byte == CH_TAB))) begin
        sp = sp + 32'd1;
      end else begin
        bd = bd + 32'd1;
        ph = PH_BODY;
      end
    end

    // end of text: pending line, then the trailing empty line
    if (s_last) begin
      if (!pair) begin
        recs[nrec] = '{line_start: st, line_number: ln, leading_spaces: sp,
                       content_length: bd,
                       terminator_length: ((ph == PH_CR) || (ph == PH_LF)) ?
                                          TERM_SINGLE : TERM_NONE,
                       final_line: 1'b0};
        nrec = nrec + 2'd1;
        ln   = ln + 32'd1;
      end
      recs[nrec] = '{line_start: pos1, line_number: ln, leading_spaces: '0,
                     content_length: '0, terminator_length: TERM_NONE,
                     final_line: 1'b1};
      nrec = nrec + 2'd1;
      phase_next         = PH_WS;
      byte_offset_next   = '0;
      current_start_next = '0;
      space_count_next   = '0;
      body_count_next    = '0;
      line_counter_next  = 32'd1;
    end else begin
      phase_next         = ph;
      byte_offset_next   = pos1;
      current_start_next = st;
      space_count_next   = sp;
      body_count_next    = bd;
      line_counter_next  = ln;
    end
  end

  // queue occupancy
  always_comb begin
    count_next = count;
    if (fire) begin
      count_next = count_next + (PW+1)'(nrec);
    end
    if (pop) begin
      count_next = count_next - (PW+1)'(1);
    end
  end

  // control and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid       <= 1'b0;
      phase         <= PH_WS;
      byte_offset   <= '0;
      current_start <= '0;
      space_count   <= '0;
      body_count    <= '0;
      line_counter  <= 32'd1;
      wp            <= '0;
      rp            <= '0;
      count         <= '0;
    end else begin
      if (in_ready) begin
        s_valid <= in_valid;
      end
      if (fire) begin
        phase         <= phase_next;
        byte_offset   <= byte_offset_next;
        current_start <= current_start_next;
        space_count   <= space_count_next;
        body_count    <= body_count_next;
        line_counter  <= line_counter_next;
        wp            <= wp + PW'(nrec);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      count <= count_next;
    end
  end

  // input item payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte <= data_byte;
      s_last <= last_byte;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nrec) begin
          qmem[wp + PW'(i)] <= recs[i];
        end
      end
    end
  end

  // head of queue to the output ports
  assign head              = qmem[rp];
  assign line_start        = head.line_start;
  assign line_number       = head.line_number;
  assign leading_spaces    = head.leading_spaces;
  assign content_length    = head.content_length;
  assign terminator_length = head.terminator_length;
  assign final_line        = head.final_line;

endmodule
